>>> design/bsa_pkg.sv
// Bitmap slot allocator package: sizes, widths and the control/status structs.
// No dependencies; every other design file imports it.
`default_nettype none

package bsa_pkg;

    localparam int NUM_TABLES    = 8;
    localparam int MAP_WORDS     = 16;
    localparam int BITS_PER_WORD = 32;

    localparam int TAB_W   = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
    localparam int WORD_W  = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_W   = $clog2(BITS_PER_WORD);
    localparam int ADDR_W  = TAB_W + WORD_W;
    localparam int DEPTH   = NUM_TABLES * MAP_WORDS;
    localparam int SLOT_W  = 10;
    localparam int CFG_W   = 5;
    localparam int IDX_W   = 3;

    localparam logic [SLOT_W-1:0] CNT_MAX   = '1;
    localparam logic [CFG_W-1:0]  CFG_RESET = CFG_W'(16);

    typedef enum logic {
        ST_ALLOCATED = 1'b0,
        ST_FULL      = 1'b1
    } alloc_status_t;

    typedef struct packed {
        logic start;
        logic advance;
        logic commit;
        logic fail;
    } bsa_cmd_t;

    typedef struct packed {
        logic hit;
        logic last_word;
        logic lim_zero;
        logic out_full;
    } bsa_stat_t;

endpackage

`default_nettype wire

>>> design/bsa_if.sv
// Request and response channel interfaces of the bitmap slot allocator.
// Depends on bsa_pkg for field widths.
`default_nettype none

interface bsa_req_if;
    import bsa_pkg::*;

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] table_index;

    modport source (output valid, output table_index, input ready);
    modport sink   (input valid, input table_index, output ready);
endinterface

interface bsa_rsp_if;
    import bsa_pkg::*;

    logic              valid;
    logic              ready;
    logic [SLOT_W-1:0] slot_number;
    logic              alloc_status;
    logic [SLOT_W-1:0] active_count;

    modport source (output valid, output slot_number, output alloc_status,
                    output active_count, input ready);
    modport sink   (input valid, input slot_number, input alloc_status,
                    input active_count, output ready);
endinterface

`default_nettype wire

>>> design/bsa_ctrl.sv
// Allocator controller: accepts a request, steps the word scan, ends in commit or fail.
// Depends on bsa_pkg for the command and status structs.
`default_nettype none

module bsa_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    output bsa_pkg::bsa_cmd_t    cmd,
    input  wire bsa_pkg::bsa_stat_t stat
);
    import bsa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_SCAN = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        cmd         = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (stat.lim_zero || (!stat.hit && stat.last_word))
                begin
                    if (!stat.out_full)
                    begin
                        cmd.fail   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (stat.hit)
                begin
                    if (!stat.out_full)
                    begin
                        cmd.commit = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.advance = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> design/bsa_dpath.sv
// Allocator datapath: bitmap memory, per-table counters, first-clear-bit search, result register.
// Depends on bsa_pkg; driven by bsa_ctrl through bsa_cmd_t.
`default_nettype none

module bsa_dpath (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_wr_en,
    input  wire logic [bsa_pkg::CFG_W-1:0] cfg_wr_data,
    input  wire logic [bsa_pkg::IDX_W-1:0] table_index,
    input  wire bsa_pkg::bsa_cmd_t        cmd,
    output bsa_pkg::bsa_stat_t            stat,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [bsa_pkg::SLOT_W-1:0]    slot_number,
    output logic                          alloc_status,
    output logic [bsa_pkg::SLOT_W-1:0]    active_count
);
    import bsa_pkg::*;

    logic [BITS_PER_WORD-1:0] mem [DEPTH];
    logic [DEPTH-1:0]         wr_vld_reg;

    logic [CFG_W-1:0]         words_in_use_reg;
    logic [TAB_W-1:0]         table_reg;
    logic [WORD_W-1:0]        word_reg;
    logic [BITS_PER_WORD-1:0] rd_data_reg;
    logic                     rd_vld_reg;

    logic [SLOT_W-1:0]        highest_reg [NUM_TABLES];
    logic [SLOT_W-1:0]        active_reg  [NUM_TABLES];

    logic                     out_vld_reg;
    logic [SLOT_W-1:0]        slot_reg;
    alloc_status_t            status_reg;
    logic [SLOT_W-1:0]        count_reg;

    logic [WORD_W-1:0]        rd_word;
    logic [ADDR_W-1:0]        rd_addr;
    logic [ADDR_W-1:0]        cur_addr;
    logic [BITS_PER_WORD-1:0] cur_data;
    logic [BITS_PER_WORD-1:0] free_bits;
    logic [BIT_W-1:0]         bit_idx;
    logic [BITS_PER_WORD-1:0] bit_mask;
    logic [CFG_W-1:0]         lim;
    logic [SLOT_W-1:0]        new_slot;
    logic [SLOT_W-1:0]        cur_active;
    logic [SLOT_W-1:0]        inc_active;

    assign lim      = (words_in_use_reg > CFG_W'(MAP_WORDS)) ? CFG_W'(MAP_WORDS)
                                                             : words_in_use_reg;
    assign rd_word  = cmd.advance ? word_reg + WORD_W'(1) : word_reg;
    assign rd_addr  = {table_reg, rd_word};
    assign cur_addr = {table_reg, word_reg};
    assign cur_data = rd_vld_reg ? rd_data_reg : '0;
    assign free_bits = ~cur_data;

    always_comb
    begin
        bit_idx = '0;
        for (int i = BITS_PER_WORD - 1; i >= 0; i--)
        begin
            if (free_bits[i])
            begin
                bit_idx = BIT_W'(i);
            end
        end
    end

    assign bit_mask   = BITS_PER_WORD'(1) << bit_idx;
    assign new_slot   = SLOT_W'({word_reg, bit_idx}) + SLOT_W'(1);
    assign cur_active = active_reg[table_reg];
    assign inc_active = (cur_active == CNT_MAX) ? cur_active : cur_active + SLOT_W'(1);

    assign stat.hit       = |free_bits;
    assign stat.last_word = ((CFG_W'(word_reg) + CFG_W'(1)) == lim);
    assign stat.lim_zero  = (lim == '0);
    assign stat.out_full  = out_vld_reg && !out_ready;

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
        rd_vld_reg  <= wr_vld_reg[rd_addr];
        if (cmd.commit)
        begin
            mem[cur_addr] <= cur_data | bit_mask;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            table_reg <= TAB_W'(table_index);
            word_reg  <= '0;
        end
        else if (cmd.advance)
        begin
            word_reg <= word_reg + WORD_W'(1);
        end
        if (cmd.commit)
        begin
            slot_reg   <= new_slot;
            status_reg <= ST_ALLOCATED;
            count_reg  <= inc_active;
        end
        else if (cmd.fail)
        begin
            slot_reg   <= '0;
            status_reg <= ST_FULL;
            count_reg  <= cur_active;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_vld_reg       <= '0;
            words_in_use_reg <= CFG_RESET;
            out_vld_reg      <= 1'b0;
            for (int t = 0; t < NUM_TABLES; t++)
            begin
                highest_reg[t] <= '0;
                active_reg[t]  <= '0;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                words_in_use_reg <= cfg_wr_data;
            end
            if (cmd.commit)
            begin
                wr_vld_reg[cur_addr]  <= 1'b1;
                active_reg[table_reg] <= inc_active;
                if (highest_reg[table_reg] < new_slot)
                begin
                    highest_reg[table_reg] <= new_slot;
                end
            end
            if (cmd.commit || cmd.fail)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_vld_reg;
    assign slot_number  = slot_reg;
    assign alloc_status = status_reg;
    assign active_count = count_reg;

endmodule

`default_nettype wire

>>> design/bitmap_slot_allocator.sv
// Bitmap slot allocator top level: joins controller and datapath to the channels.
// Depends on bsa_pkg, bsa_if, bsa_ctrl and bsa_dpath.
//
// Usage:
//   req (sink): one word carries table_index; the block allocates the first free
//     slot of that table's bitmap, lowest word and lowest bit first.
//   rsp (source): one word per request: slot_number (1-based, 0 on failure),
//     alloc_status (0 allocated, 1 full) and active_count after the request.
//   cfg_wr_en/cfg_wr_data write words_in_use (words scanned, capped at 16);
//     write only while no request is in flight.
// Timing: the controller steps S_IDLE, S_READ, then S_SCAN, reading up to 16 bitmap words
//   until a clear bit is found or the scan ends; one word is read per cycle from the
//   bitmap memory, which has separate read and write addresses. A new request is taken
//   only once the previous one has ended in commit or fail.
// Reset: all bitmaps read as empty, counters are zero, words_in_use is 16; the
//   block is ready right after reset with no clearing pass.
// Stall: one finished response is held in the output register; a further request
//   is scanned and then waits until that response is taken.
`default_nettype none

module bitmap_slot_allocator (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    bsa_req_if.sink                        req,
    bsa_rsp_if.source                      rsp,
    input  wire logic                      cfg_wr_en,
    input  wire logic [bsa_pkg::CFG_W-1:0] cfg_wr_data
);
    import bsa_pkg::*;

    bsa_cmd_t  cmd;
    bsa_stat_t stat;

    bsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    bsa_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .table_index  (req.table_index),
        .cmd          (cmd),
        .stat         (stat),
        .out_valid    (rsp.valid),
        .out_ready    (rsp.ready),
        .slot_number  (rsp.slot_number),
        .alloc_status (rsp.alloc_status),
        .active_count (rsp.active_count)
    );

endmodule

`default_nettype wire

>>> design/bsa_checker.sv
// Port-level checker for the bitmap slot allocator and its bind to the top level.
// Depends on bsa_pkg for field widths.
`default_nettype none

module bsa_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       req_valid,
    input wire logic                       req_ready,
    input wire logic                       rsp_valid,
    input wire logic                       rsp_ready,
    input wire logic [bsa_pkg::SLOT_W-1:0] slot_number,
    input wire logic                       alloc_status,
    input wire logic [bsa_pkg::SLOT_W-1:0] active_count
);
    import bsa_pkg::*;

    logic [1:0] pend_reg;
    logic       req_acc;
    logic       rsp_acc;

    assign req_acc = req_valid && req_ready;
    assign rsp_acc = rsp_valid && rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_reg + 2'(req_acc) - 2'(rsp_acc);
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(slot_number)
            && $stable(alloc_status) && $stable(active_count))
        else $error("response dropped or changed while stalled");

    a_no_extra_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pend_reg != 2'd0)
        else $error("response without an outstanding request");

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("too many requests in flight");

    a_full_slot: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ((alloc_status == 1'b1) == (slot_number == '0)))
        else $error("slot number disagrees with status");

    a_alloc_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !alloc_status |-> active_count != '0)
        else $error("allocation with zero active count");

endmodule

bind bitmap_slot_allocator bsa_checker u_bsa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .slot_number  (rsp.slot_number),
    .alloc_status (rsp.alloc_status),
    .active_count (rsp.active_count)
);

`default_nettype wire

>>> tb/sv/bsa_alloc_checker.sv
// Scoreboard for the bitmap slot allocator: watches the request, response and config ports.
// Keeps its own first-fit bitmap per table, predicts each response word and compares fields.
// Depends on bsa_pkg and the bsa_req_if / bsa_rsp_if interfaces.
module bsa_alloc_checker
    import bsa_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    bsa_req_if                    req_mon,
    bsa_rsp_if                    rsp_mon,
    input  wire logic             cfg_wr_en,
    input  wire logic [CFG_W-1:0] cfg_wr_data,
    output int                    pending,
    output int                    fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        alloc_status_t     status;
        logic [SLOT_W-1:0] count;
    } alloc_result_t;

    logic [BITS_PER_WORD-1:0] slot_map [NUM_TABLES][MAP_WORDS];
    logic [SLOT_W-1:0]        top_slot [NUM_TABLES];
    logic [SLOT_W-1:0]        entry_count [NUM_TABLES];
    logic [CFG_W-1:0]         scan_words;
    alloc_result_t            expected_allocs [$];

    initial fail_count = 0;

    task automatic predict_alloc(input logic [IDX_W-1:0] tab, output alloc_result_t res);
        int  limit;
        int  slot_val;
        logic found;
        res.slot   = '0;
        res.status = ST_FULL;
        res.count  = '0;
        found      = 1'b0;
        if (int'(tab) < NUM_TABLES) begin
            limit = (int'(scan_words) > MAP_WORDS) ? MAP_WORDS : int'(scan_words);
            for (int w = 0; w < limit && !found; w++) begin
                for (int b = 0; b < BITS_PER_WORD && !found; b++) begin
                    if (!slot_map[tab][w][b]) begin
                        found = 1'b1;
                        slot_map[tab][w][b] = 1'b1;
                        slot_val = w * BITS_PER_WORD + b + 1;
                        if (slot_val > int'(CNT_MAX))
                            slot_val = int'(CNT_MAX);
                        if (int'(top_slot[tab]) < slot_val)
                            top_slot[tab] = SLOT_W'(slot_val);
                        if (entry_count[tab] != CNT_MAX)
                            entry_count[tab] = entry_count[tab] + 1'b1;
                        res.slot   = SLOT_W'(w * BITS_PER_WORD + b + 1);
                        res.status = ST_ALLOCATED;
                    end
                end
            end
            res.count = entry_count[tab];
        end
    endtask

    function automatic void check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            if (fail_count < MAX_REPORTS)
                $display("mismatch on %s: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        alloc_result_t res;
        alloc_result_t exp_res;
        if (!rst_n) begin
            for (int t = 0; t < NUM_TABLES; t++) begin
                for (int w = 0; w < MAP_WORDS; w++)
                    slot_map[t][w] = '0;
                top_slot[t]    = '0;
                entry_count[t] = '0;
            end
            scan_words = CFG_RESET;
            expected_allocs.delete();
            pending <= 0;
        end
        else begin
            if (cfg_wr_en)
                scan_words = cfg_wr_data;
            if (rsp_mon.valid && rsp_mon.ready) begin
                if (expected_allocs.size() == 0) begin
                    if (fail_count < MAX_REPORTS)
                        $display("unexpected response word: slot %0d status %0d count %0d",
                                 rsp_mon.slot_number, rsp_mon.alloc_status,
                                 rsp_mon.active_count);
                    fail_count++;
                end
                else begin
                    exp_res = expected_allocs.pop_front();
                    check_field("slot_number", int'(exp_res.slot), int'(rsp_mon.slot_number));
                    check_field("alloc_status", int'(exp_res.status),
                                int'(rsp_mon.alloc_status));
                    check_field("active_count", int'(exp_res.count),
                                int'(rsp_mon.active_count));
                end
            end
            if (req_mon.valid && req_mon.ready) begin
                predict_alloc(req_mon.table_index, res);
                expected_allocs.push_back(res);
            end
            pending <= expected_allocs.size();
        end
    end

endmodule

>>> tb/sv/bitmap_slot_allocator_tb.sv
// Top of the bitmap slot allocator testbench: clock, reset, request and config stimulus.
// Instantiates the block and bsa_alloc_checker, which does all prediction and comparison.
// Depends on bsa_pkg, the bsa interfaces, bitmap_slot_allocator and bsa_alloc_checker.
module bitmap_slot_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bsa_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 80;
    localparam int END_CYCLES   = 40;

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [CFG_W-1:0] cfg_wr_data;
    int               pending;
    int               fail_count;
    int               cycle_count;
    int               send_idle_pct;
    int               recv_idle_pct;
    int               hold_left;
    logic             rsp_hold_req;

    bsa_req_if req_bus ();
    bsa_rsp_if rsp_bus ();

    bitmap_slot_allocator u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_bus),
        .rsp         (rsp_bus),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    bsa_alloc_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_mon     (req_bus),
        .rsp_mon     (rsp_bus),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .pending     (pending),
        .fail_count  (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("bitmap_slot_allocator_tb failed");
            $finish;
        end
    end

    initial
    begin
        rsp_bus.ready = 1'b0;
        hold_left     = 0;
        forever
        begin
            @(posedge clk);
            if (rsp_hold_req)
            begin
                rsp_hold_req = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                rsp_bus.ready <= 1'b0;
                hold_left--;
            end
            else
                rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_alloc(input logic [IDX_W-1:0] tab);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_bus.valid <= 1'b0;
            @(posedge clk);
        end
        req_bus.valid       <= 1'b1;
        req_bus.table_index <= tab;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        req_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_scan_words(input logic [CFG_W-1:0] value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial
    begin
        rst_n               = 1'b0;
        cfg_wr_en           = 1'b0;
        cfg_wr_data         = '0;
        req_bus.valid       = 1'b0;
        req_bus.table_index = '0;
        rsp_hold_req        = 1'b0;
        cycle_count         = 0;
        send_idle_pct       = 37;
        recv_idle_pct       = 62;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every table once at the reset scan width, then repeats on the edges
        for (int t = 0; t < NUM_TABLES; t++)
            send_alloc(IDX_W'(t));
        send_alloc(IDX_W'(0));
        send_alloc(IDX_W'(0));
        send_alloc(IDX_W'(NUM_TABLES - 1));

        // zero words scanned: every request reports full
        write_scan_words(CFG_W'(0));
        send_alloc(IDX_W'(0));
        send_alloc(IDX_W'(NUM_TABLES - 1));
        send_alloc(IDX_W'(4));

        // scan width above the bitmap size is capped
        write_scan_words(CFG_W'(31));
        send_alloc(IDX_W'(NUM_TABLES - 1));
        send_alloc(IDX_W'(0));
        send_alloc(IDX_W'(3));

        // one word per table: the low-numbered tables fill up quickly
        write_scan_words(CFG_W'(1));
        for (int i = 0; i < 130; i++)
        begin
            if ($urandom_range(9) == 0)
                send_alloc(IDX_W'($urandom_range(NUM_TABLES - 1)));
            else
                send_alloc(IDX_W'($urandom_range(2)));
        end

        write_scan_words(CFG_W'(2));
        send_idle_pct = 62;
        recv_idle_pct = 37;
        for (int i = 0; i < 140; i++)
            send_alloc(IDX_W'($urandom_range(NUM_TABLES - 1)));

        // full width, mostly one table so scans run deep
        write_scan_words(CFG_W'(16));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rsp_hold_req  = 1'b1;
        for (int i = 0; i < 300; i++)
        begin
            if (i == 150)
                wait_drained();
            if ($urandom_range(9) < 8)
                send_alloc(IDX_W'(6));
            else
                send_alloc(IDX_W'($urandom_range(NUM_TABLES - 1)));
        end

        wait_drained();
        repeat (END_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("bitmap_slot_allocator_tb passed");
        else
            $display("bitmap_slot_allocator_tb failed");
        $finish;
    end

endmodule
